// ===== hdl/ckmb_pkg.sv =====
// Shared types, codes and key tables for the console to key matrix bridge.
// No dependencies; used by every module of the block.
package ckmb_pkg;

	localparam int unsigned RowCount  = 8;
	localparam int unsigned RowBits   = 5;
	localparam int unsigned KeyCount  = RowCount * RowBits;
	localparam int unsigned KeyWidth  = 6;
	localparam int unsigned TickWidth = 16;

	localparam logic [KeyWidth-1:0] KeyCaps  = 6'd0;
	localparam logic [KeyWidth-1:0] KeySym   = 6'd36;
	localparam logic [KeyWidth-1:0] KeyUp    = 6'd23;
	localparam logic [KeyWidth-1:0] KeyDown  = 6'd24;
	localparam logic [KeyWidth-1:0] KeyRight = 6'd22;
	localparam logic [KeyWidth-1:0] KeyLeft  = 6'd19;

	localparam logic [7:0] ByteEsc     = 8'h1B;
	localparam logic [7:0] ByteBracket = 8'h5B;
	localparam logic [7:0] ByteArrowA  = 8'h41;
	localparam logic [7:0] ByteArrowB  = 8'h42;
	localparam logic [7:0] ByteArrowC  = 8'h43;
	localparam logic [7:0] ByteArrowD  = 8'h44;
	localparam logic [7:0] ByteDel     = 8'h7F;
	localparam logic [7:0] CaseFold    = 8'd32;
	localparam logic [7:0] ReadIdle    = 8'hFF;

	localparam logic [TickWidth-1:0] TickMax        = 16'hFFFF;
	localparam logic [TickWidth-1:0] IdleTicksReset = 16'd50;
	localparam logic [TickWidth-1:0] EscTicksReset  = 16'd50;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_READ = 2'd2,
		ACT_KEY  = 2'd3
	} action_t;

	typedef enum logic {
		REG_IDLE_TICKS = 1'b0,
		REG_ESC_TICKS  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_OPEN = 2'd1,
		ESC_LAST = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic                mapped;
		logic [KeyWidth-1:0] key;
		logic                caps;
		logic                sym;
	} dec_t;

	localparam logic [KeyWidth-1:0] LetterKey [26] = '{
		6'd5, 6'd39, 6'd3, 6'd7, 6'd12, 6'd8, 6'd9, 6'd34, 6'd27, 6'd33, 6'd32, 6'd31,
		6'd37, 6'd38, 6'd26, 6'd25, 6'd10, 6'd13, 6'd6, 6'd14, 6'd28, 6'd4, 6'd11,
		6'd2, 6'd29, 6'd1
	};

	localparam logic [KeyWidth-1:0] DigitKey [10] = '{
		6'd20, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd23, 6'd22, 6'd21
	};

endpackage

// ===== hdl/console_to_key_matrix_bridge_unit.sv =====
// Top level of the console to key matrix bridge: request register, key matrix
// state, combo and escape logic, result register. Depends on ckmb_pkg, ckmb_decode.
//
// One request per clock while the result side does not stall. A request waits in
// the input register and its result is then loaded into the result register; the
// only thing that slows the flow is stall on the result side, which holds the
// result register and then the input register. All matrix and timer state
// updates in the cycle the request leaves the input register.
module console_to_key_matrix_bridge_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ckmb_pkg::TickWidth-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [7:0]                     byte_value,
	input  logic [15:0]                    port_address,
	input  logic [5:0]                     key_index,
	input  logic                           key_down,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     read_data,
	output logic                           key_held
);
	import ckmb_pkg::*;

	// input register
	logic                 valid_s1;
	action_t              action_s1;
	logic [7:0]           byte_s1;
	logic [15:0]          addr_s1;
	logic [KeyWidth-1:0]  key_s1;
	logic                 down_s1;
	logic                 adv_s1;

	// configuration and state
	logic [TickWidth-1:0] idle_ticks_q, esc_ticks_q;
	logic [KeyCount-1:0]  rows_q, rows_d;
	logic                 held_valid_q, held_valid_d;
	logic [KeyWidth-1:0]  held_key_q, held_key_d;
	logic                 held_caps_q, held_caps_d;
	logic                 held_sym_q, held_sym_d;
	esc_phase_t           phase_q, phase_d;
	logic                 bracket_q, bracket_d;
	logic [TickWidth-1:0] tick_q, tick_d;

	// result register
	logic                 out_valid_q;
	logic [7:0]           read_data_q;
	logic                 key_held_q;

	ckmb_pkg::dec_t       dec;
	logic                 do_press, do_release, same_combo;
	logic [KeyWidth-1:0]  press_key;
	logic                 press_caps, press_sym;
	logic [KeyCount-1:0]  rel_mask, press_mask, direct_mask;
	logic [TickWidth-1:0] tick_inc, tick_limit;
	logic [7:0]           read_val;

	ckmb_decode u_decode (
		.byte_in (byte_s1),
		.dec     (dec)
	);

	function automatic logic [KeyCount-1:0] key_bit(input logic [KeyWidth-1:0] k);
		logic [KeyCount-1:0] m;
		m = '0;
		if (k < KeyWidth'(KeyCount)) m[k] = 1'b1;
		return m;
	endfunction

	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign key_held  = key_held_q;

	always_comb begin
		held_valid_d = held_valid_q;
		held_key_d   = held_key_q;
		held_caps_d  = held_caps_q;
		held_sym_d   = held_sym_q;
		phase_d      = phase_q;
		bracket_d    = bracket_q;
		tick_d       = tick_q;
		do_press     = 1'b0;
		do_release   = 1'b0;
		press_key    = dec.key;
		press_caps   = dec.caps;
		press_sym    = dec.sym;
		direct_mask  = key_bit(key_s1);
		tick_inc     = (tick_q < TickMax) ? tick_q + 1'b1 : tick_q;
		tick_limit   = (phase_q != ESC_NONE) ? esc_ticks_q : idle_ticks_q;
		read_val     = ReadIdle;

		unique case (action_s1)
			ACT_BYTE: begin
				unique case (phase_q)
					ESC_OPEN: begin
						bracket_d = (byte_s1 == ByteBracket);
						phase_d   = ESC_LAST;
					end
					ESC_LAST: begin
						phase_d    = ESC_NONE;
						tick_d     = '0;
						bracket_d  = 1'b0;
						press_caps = 1'b1;
						press_sym  = 1'b0;
						if (bracket_q) begin
							priority if (byte_s1 == ByteArrowA) begin
								do_press = 1'b1; press_key = KeyUp;
							end else if (byte_s1 == ByteArrowB) begin
								do_press = 1'b1; press_key = KeyDown;
							end else if (byte_s1 == ByteArrowC) begin
								do_press = 1'b1; press_key = KeyRight;
							end else if (byte_s1 == ByteArrowD) begin
								do_press = 1'b1; press_key = KeyLeft;
							end
						end
					end
					default: begin
						tick_d = '0;
						if (byte_s1 == ByteEsc) begin
							phase_d   = ESC_OPEN;
							bracket_d = 1'b0;
						end else begin
							do_press = dec.mapped;
						end
					end
				endcase
			end
			ACT_TICK: begin
				if (phase_q == ESC_NONE && !held_valid_q) begin
					tick_d = '0;
				end else if (tick_inc >= tick_limit) begin
					tick_d = '0;
					if (phase_q != ESC_NONE) begin
						phase_d   = ESC_NONE;
						bracket_d = 1'b0;
					end else begin
						do_release = 1'b1;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			ACT_READ: begin
				for (int r = 0; r < RowCount; r++) begin
					if (!addr_s1[8+r]) read_val &= {3'b111, rows_q[r*RowBits +: RowBits]};
				end
			end
			default: ;
		endcase

		// a repeated combination changes nothing
		same_combo = held_valid_q && held_key_q == press_key && held_caps_q == press_caps
			&& held_sym_q == press_sym;
		if (do_press && same_combo) do_press = 1'b0;
		if (do_press) do_release = 1'b1;

		rel_mask = '0;
		if (do_release && held_valid_q) begin
			rel_mask = key_bit(held_key_q);
			if (held_sym_q) rel_mask |= key_bit(KeySym);
			if (held_caps_q) rel_mask |= key_bit(KeyCaps);
			held_valid_d = 1'b0;
		end
		press_mask = '0;
		if (do_press) begin
			press_mask = key_bit(press_key);
			if (press_caps) press_mask |= key_bit(KeyCaps);
			if (press_sym) press_mask |= key_bit(KeySym);
			held_valid_d = 1'b1;
			held_key_d   = press_key;
			held_caps_d  = press_caps;
			held_sym_d   = press_sym;
		end

		rows_d = (rows_q | rel_mask) & ~press_mask;
		if (action_s1 == ACT_KEY) begin
			rows_d = down_s1 ? (rows_q & ~direct_mask) : (rows_q | direct_mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action_t'(action);
			byte_s1   <= byte_value;
			addr_s1   <= port_address;
			key_s1    <= key_index;
			down_s1   <= key_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= IdleTicksReset;
			esc_ticks_q  <= EscTicksReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IDLE_TICKS: idle_ticks_q <= cfg_data;
				REG_ESC_TICKS:  esc_ticks_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= '1;
			held_valid_q <= 1'b0;
			held_key_q   <= '0;
			held_caps_q  <= 1'b0;
			held_sym_q   <= 1'b0;
			phase_q      <= ESC_NONE;
			bracket_q    <= 1'b0;
			tick_q       <= '0;
		end else if (adv_s1) begin
			rows_q       <= rows_d;
			held_valid_q <= held_valid_d;
			held_key_q   <= held_key_d;
			held_caps_q  <= held_caps_d;
			held_sym_q   <= held_sym_d;
			phase_q      <= phase_d;
			bracket_q    <= bracket_d;
			tick_q       <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_q <= read_val;
			key_held_q  <= held_valid_d;
		end
	end

endmodule

// ===== hdl/ckmb_decode.sv =====
// Console byte decoder: case fold, letter and digit tables, symbol map.
// Depends on ckmb_pkg. Purely combinational.
module ckmb_decode (
	input  logic [7:0]    byte_in,
	output ckmb_pkg::dec_t dec
);
	import ckmb_pkg::*;

	logic [7:0] folded;
	logic [7:0] letter_ofs;
	logic [7:0] digit_ofs;

	always_comb begin
		folded     = (byte_in >= 8'h61 && byte_in <= 8'h7A) ? byte_in - CaseFold : byte_in;
		letter_ofs = folded - ByteArrowA;
		digit_ofs  = folded - 8'h30;
		dec        = '{mapped: 1'b1, key: '0, caps: 1'b0, sym: 1'b0};
		if (folded >= 8'h41 && folded <= 8'h5A) begin
			dec.key = LetterKey[letter_ofs[4:0]];
		end else if (folded >= 8'h30 && folded <= 8'h39) begin
			dec.key = DigitKey[digit_ofs[3:0]];
		end else begin
			dec.sym = 1'b1;
			unique case (folded)
				8'h20: begin dec.key = 6'd35; dec.sym = 1'b0; end
				8'h0D, 8'h0A: begin dec.key = 6'd30; dec.sym = 1'b0; end
				8'h08, ByteDel: begin
					dec.key  = 6'd20;
					dec.sym  = 1'b0;
					dec.caps = 1'b1;
				end
				8'h21: dec.key = 6'd15;
				8'h40: dec.key = 6'd16;
				8'h23: dec.key = 6'd17;
				8'h24: dec.key = 6'd18;
				8'h25: dec.key = 6'd19;
				8'h26: dec.key = 6'd24;
				8'h27: dec.key = 6'd23;
				8'h28: dec.key = 6'd22;
				8'h29: dec.key = 6'd21;
				8'h5F: dec.key = 6'd20;
				8'h3C: dec.key = 6'd13;
				8'h3E: dec.key = 6'd14;
				8'h22: dec.key = 6'd25;
				8'h2B: dec.key = 6'd32;
				8'h2D: dec.key = 6'd33;
				8'h3D: dec.key = 6'd31;
				8'h2A: dec.key = 6'd39;
				8'h2F: dec.key = 6'd4;
				8'h3F: dec.key = 6'd3;
				8'h2C: dec.key = 6'd38;
				8'h2E: dec.key = 6'd37;
				8'h3B: dec.key = 6'd26;
				8'h3A: dec.key = 6'd1;
				default: begin
					dec.mapped = 1'b0;
					dec.sym    = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ckmb_checker.sv =====
// Port-level checks for the console to key matrix bridge, bound to the top level.
// Depends on ckmb_pkg and console_to_key_matrix_bridge_unit.
module ckmb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       key_held
);
	import ckmb_pkg::*;

	// unused row positions always read as one
	a_read_top_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> read_data[7:5] == ReadIdle[7:5])
		else $error("read_data upper bits not set");

	// with the result register empty, the input side never backs up
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(key_held))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result withdrawn while stalled");

endmodule

bind console_to_key_matrix_bridge_unit ckmb_checker u_ckmb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.key_held  (key_held)
);

// ===== tb/tb.sv =====
// Self-checking bench for console_to_key_matrix_bridge_unit: a directed table, then random
// phases under several timer settings; the first table steps have fixed results, the rest
// are checked against a matrix predictor kept here. Depends on ckmb_pkg and the block RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ckmb_pkg::*;

	typedef enum logic [1:0] {SH_NONE, SH_CAPS, SH_SYM} shift_t;

	typedef struct packed {
		action_t     act;
		logic [7:0]  b;
		logic [15:0] addr;
		logic [5:0]  k;
		logic        down;
	} req_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       held;
	} result_t;

	typedef struct packed {
		req_t    req;
		logic    fixed;
		result_t want;
	} step_t;

	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_REQS  = 125;
	localparam int unsigned STUCK_LIMIT = 5000;
	localparam int unsigned DIR_COUNT   = 25;

	localparam logic [15:0] IDLE_SET [PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd6, 16'd2};
	localparam logic [15:0] ESC_SET  [PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd9, 16'd5};

	localparam logic [5:0] ALPHA_KEYS [26] = '{
		6'd5, 6'd39, 6'd3, 6'd7, 6'd12, 6'd8, 6'd9, 6'd34, 6'd27, 6'd33, 6'd32, 6'd31, 6'd37,
		6'd38, 6'd26, 6'd25, 6'd10, 6'd13, 6'd6, 6'd14, 6'd28, 6'd4, 6'd11, 6'd2, 6'd29, 6'd1
	};
	localparam logic [5:0] NUM_KEYS [10] = '{
		6'd20, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd23, 6'd22, 6'd21
	};
	localparam logic [7:0] PUNCT_BYTES [28] = '{
		8'h20, 8'h0D, 8'h0A, 8'h08, 8'h7F, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h5F, 8'h3C, 8'h3E, 8'h22, 8'h2B, 8'h2D, 8'h3D, 8'h2A, 8'h2F, 8'h3F,
		8'h2C, 8'h2E, 8'h3B, 8'h3A
	};

	// Reset view, extremes, ordinary keys, both shifts, escape sequences good and bad,
	// direct keys inside and outside the matrix.
	localparam step_t DIR_STEPS [DIR_COUNT] = '{
		'{'{ACT_READ, 8'h00, 16'h0000, 6'd0,  1'b0}, 1'b1, '{ReadIdle, 1'b0}},
		'{'{ACT_READ, 8'h00, 16'hFF00, 6'd0,  1'b0}, 1'b1, '{ReadIdle, 1'b0}},
		'{'{ACT_TICK, 8'h00, 16'h0000, 6'd0,  1'b0}, 1'b1, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h61, 16'h0000, 6'd0,  1'b0}, 1'b1, '{ReadIdle, 1'b1}},
		'{'{ACT_READ, 8'h00, 16'hFD00, 6'd0,  1'b0}, 1'b1, '{8'hFE,    1'b1}},
		'{'{ACT_BYTE, 8'h61, 16'h0000, 6'd0,  1'b0}, 1'b1, '{ReadIdle, 1'b1}},
		'{'{ACT_BYTE, 8'h5A, 16'hFFFF, 6'd63, 1'b1}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h39, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h7F, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h21, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_READ, 8'hFF, 16'h00FF, 6'd63, 1'b1}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h00, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h1B, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_TICK, 8'h00, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h5B, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h41, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h1B, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h1B, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_BYTE, 8'h42, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_KEY,  8'h00, 16'h0000, 6'd63, 1'b1}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_KEY,  8'h00, 16'h0000, 6'd39, 1'b1}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_KEY,  8'h00, 16'h0000, 6'd0,  1'b1}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_READ, 8'h00, 16'h7F00, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_KEY,  8'h00, 16'h0000, 6'd39, 1'b0}, 1'b0, '{ReadIdle, 1'b0}},
		'{'{ACT_READ, 8'h00, 16'h0000, 6'd0,  1'b0}, 1'b0, '{ReadIdle, 1'b0}}
	};

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	cfg_reg_t       cfg_index;
	logic [15:0]    cfg_data;
	logic           in_valid;
	logic           in_stall;
	logic [1:0]     action;
	logic [7:0]     byte_value;
	logic [15:0]    port_address;
	logic [5:0]     key_index;
	logic           key_down;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [7:0]     read_data;
	logic           key_held;

	req_t           cur_req;
	logic           cur_fixed;
	result_t        cur_want;

	// predictor state
	logic [4:0]     mx_rows [RowCount];
	logic           hold_on;
	logic [5:0]     hold_key;
	logic           hold_caps;
	logic           hold_sym;
	esc_phase_t     esc_state;
	logic           saw_bracket;
	logic [15:0]    idle_count;
	logic [15:0]    idle_limit;
	logic [15:0]    esc_limit;

	result_t        due_outputs [$];
	req_t           queued_reqs [$];
	logic [7:0]     last_byte = 8'h41;
	int unsigned    burst_left = 0;
	int unsigned    stall_left = 0;
	int unsigned    stall_mode = 0;
	int unsigned    stuck = 0;
	int unsigned    fault_count = 0;
	int unsigned    n_checked = 0;
	int unsigned    n_bytes = 0, n_ticks = 0, n_reads = 0, n_keys = 0;
	int unsigned    n_arrows = 0, n_releases = 0, n_esc_drops = 0;

	assign action       = cur_req.act;
	assign byte_value   = cur_req.b;
	assign port_address = cur_req.addr;
	assign key_index    = cur_req.k;
	assign key_down     = cur_req.down;

	console_to_key_matrix_bridge_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.byte_value   (byte_value),
		.port_address (port_address),
		.key_index    (key_index),
		.key_down     (key_down),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.key_held     (key_held)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void mx_set(input logic [5:0] k, input logic down);
		if (k >= KeyCount) return;
		mx_rows[k / RowBits][k % RowBits] = !down;
	endfunction

	function automatic void drop_combo();
		if (!hold_on) return;
		mx_set(hold_key, 1'b0);
		if (hold_sym) mx_set(KeySym, 1'b0);
		if (hold_caps) mx_set(KeyCaps, 1'b0);
		hold_on = 1'b0;
	endfunction

	function automatic void hold_combo(input logic [5:0] k, input logic caps, input logic sym);
		if (hold_on && hold_key == k && hold_caps == caps && hold_sym == sym) return;
		drop_combo();
		if (caps) mx_set(KeyCaps, 1'b1);
		if (sym) mx_set(KeySym, 1'b1);
		mx_set(k, 1'b1);
		hold_on   = 1'b1;
		hold_key  = k;
		hold_caps = caps;
		hold_sym  = sym;
	endfunction

	function automatic logic lookup_byte(input logic [7:0] raw, output logic [5:0] k,
			output shift_t sh);
		logic [7:0] c;
		logic       found;
		c     = raw;
		found = 1'b1;
		k     = '0;
		sh    = SH_SYM;
		if (c >= 8'h61 && c <= 8'h7A) c = c - CaseFold;
		if (c >= 8'h41 && c <= 8'h5A) begin
			k  = ALPHA_KEYS[c - 8'h41];
			sh = SH_NONE;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			k  = NUM_KEYS[c - 8'h30];
			sh = SH_NONE;
		end else begin
			case (c)
				8'h20: begin
					k  = 6'd35;
					sh = SH_NONE;
				end
				8'h0D, 8'h0A: begin
					k  = 6'd30;
					sh = SH_NONE;
				end
				8'h08, ByteDel: begin
					k  = 6'd20;
					sh = SH_CAPS;
				end
				8'h21: k = 6'd15;
				8'h40: k = 6'd16;
				8'h23: k = 6'd17;
				8'h24: k = 6'd18;
				8'h25: k = 6'd19;
				8'h26: k = 6'd24;
				8'h27: k = 6'd23;
				8'h28: k = 6'd22;
				8'h29: k = 6'd21;
				8'h5F: k = 6'd20;
				8'h3C: k = 6'd13;
				8'h3E: k = 6'd14;
				8'h22: k = 6'd25;
				8'h2B: k = 6'd32;
				8'h2D: k = 6'd33;
				8'h3D: k = 6'd31;
				8'h2A: k = 6'd39;
				8'h2F: k = 6'd4;
				8'h3F: k = 6'd3;
				8'h2C: k = 6'd38;
				8'h2E: k = 6'd37;
				8'h3B: k = 6'd26;
				8'h3A: k = 6'd1;
				default: found = 1'b0;
			endcase
		end
		return found;
	endfunction

	function automatic void apply_byte(input logic [7:0] b);
		logic [5:0] k;
		shift_t     sh;
		if (esc_state == ESC_OPEN) begin
			// the byte after ESC is taken raw, another ESC included
			saw_bracket = (b == ByteBracket);
			esc_state   = ESC_LAST;
			return;
		end
		if (esc_state != ESC_NONE) begin
			esc_state  = ESC_NONE;
			idle_count = '0;
			if (saw_bracket) begin
				case (b)
					ByteArrowA: hold_combo(KeyUp, 1'b1, 1'b0);
					ByteArrowB: hold_combo(KeyDown, 1'b1, 1'b0);
					ByteArrowC: hold_combo(KeyRight, 1'b1, 1'b0);
					ByteArrowD: hold_combo(KeyLeft, 1'b1, 1'b0);
					default: ;
				endcase
				if (b >= ByteArrowA && b <= ByteArrowD) n_arrows++;
			end
			saw_bracket = 1'b0;
			return;
		end
		idle_count = '0;
		if (b == ByteEsc) begin
			esc_state   = ESC_OPEN;
			saw_bracket = 1'b0;
			return;
		end
		if (lookup_byte(b, k, sh)) hold_combo(k, sh == SH_CAPS, sh == SH_SYM);
	endfunction

	function automatic void apply_tick();
		logic [15:0] limit;
		if (esc_state == ESC_NONE && !hold_on) begin
			idle_count = '0;
			return;
		end
		if (idle_count != TickMax) idle_count++;
		limit = (esc_state != ESC_NONE) ? esc_limit : idle_limit;
		if (idle_count >= limit) begin
			if (esc_state != ESC_NONE) begin
				esc_state   = ESC_NONE;
				saw_bracket = 1'b0;
				n_esc_drops++;
			end else begin
				drop_combo();
				n_releases++;
			end
			idle_count = '0;
		end
	endfunction

	function automatic logic [7:0] row_and(input logic [15:0] addr);
		logic [7:0] v;
		v = ReadIdle;
		for (int r = 0; r < RowCount; r++)
			if (!addr[8 + r]) v &= {3'b111, mx_rows[r]};
		return v;
	endfunction

	function automatic void step_matrix(input req_t r, output result_t o);
		o.rd = ReadIdle;
		case (r.act)
			ACT_BYTE: begin
				apply_byte(r.b);
				n_bytes++;
			end
			ACT_TICK: begin
				apply_tick();
				n_ticks++;
			end
			ACT_READ: begin
				o.rd = row_and(r.addr);
				n_reads++;
			end
			default: begin
				mx_set(r.k, r.down);
				n_keys++;
			end
		endcase
		o.held = hold_on;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic req_t rand_req(input action_t a);
		req_t r;
		r.act  = a;
		r.b    = 8'($urandom);
		r.addr = 16'($urandom);
		r.k    = 6'($urandom);
		r.down = 1'($urandom);
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned p;
		logic [7:0]  b;
		p = $urandom_range(0, 99);
		if (p < 35)
			b = 8'(8'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 32 : 0));
		else if (p < 50)
			b = 8'(8'h30 + $urandom_range(0, 9));
		else if (p < 80)
			b = PUNCT_BYTES[$urandom_range(0, 27)];
		else if (p < 88)
			b = last_byte;
		else
			b = 8'($urandom_range(0, 255));
		last_byte = b;
		return b;
	endfunction

	function automatic void push_ticks(input int unsigned n);
		repeat (n) queued_reqs.push_back(rand_req(ACT_TICK));
	endfunction

	function automatic void plan_reqs();
		req_t        r;
		int unsigned p;
		logic [7:0]  sel;
		p = $urandom_range(0, 99);
		r = rand_req(ACT_BYTE);
		if (p < 15) begin
			// mostly well-formed arrow sequences, ticks may fall inside them
			r.b = ByteEsc;
			queued_reqs.push_back(r);
			push_ticks($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
			r.b = ($urandom_range(0, 99) < 85) ? ByteBracket : pick_byte();
			queued_reqs.push_back(r);
			push_ticks($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
			case ($urandom_range(0, 4))
				0: r.b = ByteArrowA;
				1: r.b = ByteArrowB;
				2: r.b = ByteArrowC;
				3: r.b = ByteArrowD;
				default: r.b = pick_byte();
			endcase
			queued_reqs.push_back(r);
		end else if (p < 45) begin
			r.b = pick_byte();
			queued_reqs.push_back(r);
		end else if (p < 65) begin
			push_ticks($urandom_range(1, 8));
		end else if (p < 82) begin
			r = rand_req(ACT_READ);
			case ($urandom_range(0, 3))
				0: sel = ~(8'd1 << $urandom_range(0, 7));
				1: sel = 8'h00;
				2: sel = 8'hFF;
				default: sel = 8'($urandom);
			endcase
			r.addr[15:8] = sel;
			queued_reqs.push_back(r);
		end else begin
			r = rand_req(ACT_KEY);
			r.k = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 39))
				: 6'($urandom_range(40, 63));
			queued_reqs.push_back(r);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_req(input req_t r, input logic fixed, input result_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cur_req   <= r;
		cur_fixed <= fixed;
		cur_want  <= want;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (due_outputs.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IDLE_TICKS) idle_limit = val;
		else esc_limit = val;
		@(negedge clk);
	endtask

	// receiver stall: modes of random length, from never to mostly stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 25);
			2: out_stall <= ($urandom_range(0, 99) < 65);
			default: out_stall <= (stall_left % 3 != 0);
		endcase
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		result_t exp_res;
		result_t pred;
		logic    progress;
		progress = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_matrix(cur_req, pred);
				if (cur_fixed) pred = cur_want;
				due_outputs.push_back(pred);
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (due_outputs.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: result with no request outstanding: read_data %02h key_held %0d",
							$realtime, read_data, key_held);
					fault_count++;
				end else begin
					exp_res = due_outputs.pop_front();
					n_checked++;
					if (read_data !== exp_res.rd || key_held !== exp_res.held) begin
						if (fault_count < 10)
							$display("%0t: result %0d: read_data exp %02h got %02h, key_held exp %0d got %0d",
								$realtime, n_checked, exp_res.rd, read_data, exp_res.held, key_held);
						fault_count++;
					end
				end
			end
			stuck = progress ? 0 : stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					stuck, due_outputs.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		req_t r;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_IDLE_TICKS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		cur_req   = '0;
		cur_fixed = 1'b0;
		cur_want  = '0;
		for (int i = 0; i < RowCount; i++) mx_rows[i] = '1;
		hold_on     = 1'b0;
		hold_key    = '0;
		hold_caps   = 1'b0;
		hold_sym    = 1'b0;
		esc_state   = ESC_NONE;
		saw_bracket = 1'b0;
		idle_count  = '0;
		idle_limit  = IdleTicksReset;
		esc_limit   = EscTicksReset;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_COUNT; i++)
			send_req(DIR_STEPS[i].req, DIR_STEPS[i].fixed, DIR_STEPS[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(REG_IDLE_TICKS, IDLE_SET[ph]);
			write_reg(REG_ESC_TICKS, ESC_SET[ph]);
			for (int n = 0; n < PHASE_REQS; n++) begin
				if (ph == 3 && n == PHASE_REQS / 2) drain();
				if (queued_reqs.size() == 0) plan_reqs();
				r = queued_reqs.pop_front();
				send_req(r, 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		fault_count += due_outputs.size();
		$display("%0d results checked: %0d console bytes, %0d ticks, %0d reads, %0d direct keys",
			n_checked, n_bytes, n_ticks, n_reads, n_keys);
		$display("%0d arrow sequences, %0d idle releases, %0d abandoned escapes, %0d failures",
			n_arrows, n_releases, n_esc_drops, fault_count);
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ckmb_pkg.sv
hdl/ckmb_decode.sv
hdl/console_to_key_matrix_bridge_unit.sv
hdl/ckmb_checker.sv
tb/tb.sv
